// ===== hdl/byte_ring_fifo_macros.svh =====
// Assertion macros used by the byte ring FIFO checker
`ifndef BYTE_RING_FIFO_MACROS_SVH
`define BYTE_RING_FIFO_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define BRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/brf_pkg.sv =====
// Shared types and constants of the byte ring FIFO
package brf_pkg;

   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 12;
   localparam int ACTION_W   = 3;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   // Action codes; codes beyond query act as a query
   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH  = 3'd0,
      ACT_POP   = 3'd1,
      ACT_PEEK  = 3'd2,
      ACT_SKIP  = 3'd3,
      ACT_CLEAR = 3'd4,
      ACT_QUERY = 3'd5
   } action_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_item;
      logic execute;
      logic load_result;
   } cmd_type;

endpackage

// ===== hdl/brf_ctrl.sv =====
// Controller state machine of the byte ring FIFO
module brf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output brf_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SEND = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   // Output register may take a new result when empty or being drained
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Decode commands from the current state
   always_comb begin
      cmd.load_item   = req_tvalid && (state_ff == ST_IDLE);
      cmd.execute     = (state_ff == ST_EXEC);
      cmd.load_result = (state_ff == ST_SEND) && slot_free;
   end

   // Advance through accept, execute and result load
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result valid until its transfer
   always_comb begin
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/brf_datapath.sv =====
// Datapath of the byte ring FIFO: indices, byte store and result register
module brf_datapath #(
   parameter int CAPACITY = 4095
) (
   input  logic                               clock,
   input  logic                               reset,
   input  brf_pkg::cmd_type                   cmd,
   input  logic [brf_pkg::ACTION_W-1:0]       req_tuser,
   input  logic [brf_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [0:0]                         rsp_tuser,
   output logic [brf_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int SLOTS = CAPACITY + 1;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int SUM_W = ((IDX_W > brf_pkg::COUNT_W) ? IDX_W : brf_pkg::COUNT_W) + 1;
   localparam logic [SUM_W-1:0] SLOTS_S = SUM_W'(SLOTS);
   localparam logic [IDX_W-1:0] CAP_U   = IDX_W'(CAPACITY);

   // Latched item
   brf_pkg::action_type               action_ff;
   logic [brf_pkg::BYTE_W-1:0]        data_ff;
   logic [brf_pkg::COUNT_W-1:0]       count_ff;

   // Ring state
   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] rear_ff, rear_in;
   logic [IDX_W-1:0] used_ff, used_in;

   // Outcome of the execute step
   logic                        refused_ff, refused_in;
   logic                        read_ok_ff;
   logic                        rd_en, wr_en;
   logic [brf_pkg::BYTE_W-1:0]  rd_data_ff;

   // Result register
   logic                        rsp_status_ff;
   logic [brf_pkg::BYTE_W-1:0]  rsp_byte_ff;
   logic [brf_pkg::COUNT_W-1:0] rsp_used_ff;
   logic [brf_pkg::COUNT_W-1:0] rsp_free_ff;

   // Address arithmetic
   logic [SUM_W-1:0] count_s, used_s, front_s, step_s, sum_s, wrap_s;
   logic [IDX_W-1:0] front_adv, rear_adv;

   logic [brf_pkg::BYTE_W-1:0] byte_store [SLOTS];

   assign rsp_tuser = rsp_status_ff;
   assign rsp_tdata = {rsp_free_ff, rsp_used_ff, rsp_byte_ff};

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff <= brf_pkg::action_type'(req_tuser);
         data_ff   <= req_tdata[brf_pkg::BYTE_W-1:0];
         count_ff  <= req_tdata[brf_pkg::BYTE_W +: brf_pkg::COUNT_W];
      end
   end

   // Advance the front by one, by count, or to the peek slot, wrapping past CAPACITY
   always_comb begin
      count_s = SUM_W'(count_ff);
      used_s  = SUM_W'(used_ff);
      front_s = SUM_W'(front_ff);
      case (action_ff)
         brf_pkg::ACT_PEEK: step_s = count_s + SUM_W'(1);
         brf_pkg::ACT_SKIP: step_s = count_s;
         default:           step_s = SUM_W'(1);
      endcase
      sum_s     = front_s + step_s;
      wrap_s    = (sum_s >= SLOTS_S) ? (sum_s - SLOTS_S) : sum_s;
      front_adv = wrap_s[IDX_W-1:0];
      rear_adv  = (rear_ff == CAP_U) ? '0 : (rear_ff + IDX_W'(1));
   end

   // Decide the action, refusing overflow and underflow
   always_comb begin
      refused_in = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      front_in   = front_ff;
      rear_in    = rear_ff;
      used_in    = used_ff;
      case (action_ff)
         brf_pkg::ACT_PUSH: begin
            if (used_ff == CAP_U) begin
               refused_in = 1'b1;
            end else begin
               rear_in = rear_adv;
               used_in = used_ff + IDX_W'(1);
               wr_en   = 1'b1;
            end
         end
         brf_pkg::ACT_POP: begin
            if (used_ff == '0) begin
               refused_in = 1'b1;
            end else begin
               front_in = front_adv;
               used_in  = used_ff - IDX_W'(1);
               rd_en    = 1'b1;
            end
         end
         brf_pkg::ACT_PEEK: begin
            if (count_s >= used_s) begin
               refused_in = 1'b1;
            end else begin
               rd_en = 1'b1;
            end
         end
         brf_pkg::ACT_SKIP: begin
            if (count_s > used_s) begin
               refused_in = 1'b1;
            end else begin
               front_in = front_adv;
               used_in  = used_ff - IDX_W'(count_ff);
            end
         end
         brf_pkg::ACT_CLEAR: begin
            front_in = rear_ff;
            used_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // Update the ring indices
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         used_ff  <= '0;
      end else if (cmd.execute) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         used_ff  <= used_in;
      end
   end

   // Byte store: write at the new rear, read at the new front or peek slot
   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) begin
         byte_store[rear_adv] <= data_ff;
      end
      if (cmd.execute && rd_en) begin
         rd_data_ff <= byte_store[front_adv];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         refused_ff <= refused_in;
         read_ok_ff <= rd_en;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_status_ff <= refused_ff;
         rsp_byte_ff   <= read_ok_ff ? rd_data_ff : '0;
         rsp_used_ff   <= brf_pkg::COUNT_W'(used_ff);
         rsp_free_ff   <= brf_pkg::COUNT_W'(CAP_U - used_ff);
      end
   end

endmodule

// ===== hdl/byte_ring_fifo.sv =====
// Top level of the byte ring FIFO
// Byte FIFO of CAPACITY bytes in a ring store of CAPACITY+1 slots. Each request
// is one action (push, pop, peek at offset, skip count, clear, query; codes 6 and
// 7 act as a query) and returns exactly one response with a refused flag, the
// byte popped or peeked (zero otherwise) and the used and free counts after the
// action, each masked to 12 bits. Pushes when full, pops when empty and peeks or
// skips beyond the stored bytes are refused and change nothing. An item passes
// through accept, execute (index update and the registered store access), then
// load into the response register, which waits while a stalled result is still
// held there; the next request is accepted the cycle after that load, so a new
// request is taken only once the last result is loaded. The store needs no
// clearing after reset.
module byte_ring_fifo #(
   parameter int CAPACITY = 4095
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [brf_pkg::REQ_DATA_W-1:0] req_tdata,  // data_byte[7:0], count[19:8], zero
   input  logic [brf_pkg::ACTION_W-1:0]   req_tuser,  // action[2:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [brf_pkg::RSP_DATA_W-1:0] rsp_tdata,  // read_byte[7:0], used_bytes[19:8],
                                                      // free_bytes[31:20]
   output logic [0:0]                     rsp_tuser   // status[0]
);

   brf_pkg::cmd_type cmd;

   brf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   brf_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== hdl/brf_checker.sv =====
// Port-level assertions for the byte ring FIFO and their bind
`include "byte_ring_fifo_macros.svh"

module brf_checker #(
   parameter int CAPACITY = 4095
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [brf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]                     rsp_tuser
);

   localparam logic [brf_pkg::COUNT_W-1:0] CAP_12 = brf_pkg::COUNT_W'(CAPACITY);

   logic [brf_pkg::COUNT_W-1:0]   count_sum;
   logic [brf_pkg::RSP_DATA_W:0]  rsp_word;
   logic                          rsp_stall;
   logic                          req_xfer;
   logic                          refused;
   logic                          byte_zero;
   logic                          sum_ok;

   assign count_sum = rsp_tdata[19:8] + rsp_tdata[31:20];
   assign rsp_word  = {rsp_tuser, rsp_tdata};
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_xfer  = req_tvalid && req_tready;
   assign refused   = rsp_tvalid && rsp_tuser[0];
   assign byte_zero = (rsp_tdata[7:0] == '0);
   assign sum_ok    = (count_sum == CAP_12);

   // A stalled response stays valid
   `BRF_ASSERT_NEXT(a_valid_hold, clock, reset, rsp_stall, rsp_tvalid, "stalled response dropped")

   // A stalled response holds its payload
   `BRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_word), "payload moved in stall")

   // Used and free always add up to the capacity
   `BRF_ASSERT_NOW(a_count_sum, clock, reset, rsp_tvalid, sum_ok, "used plus free is off")

   // A refused action returns no byte
   `BRF_ASSERT_NOW(a_refused_byte, clock, reset, refused, byte_zero, "refused response has a byte")

   // One request at a time: ready drops after each request transfer
   `BRF_ASSERT_NEXT(a_one_item, clock, reset, req_xfer, !req_tready, "request accepted while busy")

endmodule

bind byte_ring_fifo brf_checker #(.CAPACITY(CAPACITY)) u_brf_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the byte ring FIFO: directed, deep fill and random traffic
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY     = 4095;
   localparam int SLOTS        = CAPACITY + 1;
   localparam int DEEP_FILL    = 500;
   localparam int RANDOM_ITEMS = 930;
   localparam int CYCLE_LIMIT  = 400000;

   // Codes beyond query; the block treats them as a query
   localparam logic [brf_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [brf_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   typedef struct packed {
      logic                        refused;
      logic [brf_pkg::BYTE_W-1:0]  read_byte;
      logic [brf_pkg::COUNT_W-1:0] used_bytes;
      logic [brf_pkg::COUNT_W-1:0] free_bytes;
   } fifo_outcome_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [brf_pkg::REQ_DATA_W-1:0] req_tdata = '0;   // data_byte[7:0], count[19:8], zero
   logic [brf_pkg::ACTION_W-1:0]   req_tuser = '0;   // action[2:0]
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [brf_pkg::RSP_DATA_W-1:0] rsp_tdata;        // read_byte[7:0], used_bytes[19:8],
                                                     // free_bytes[31:20]
   logic [0:0]                     rsp_tuser;        // status[0]

   // Mirror of the FIFO contents and indices
   logic [brf_pkg::BYTE_W-1:0] ring_bytes [SLOTS];
   int                         ring_front = 0;
   int                         ring_rear  = 0;

   fifo_outcome_type outcomes_due [$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               rsp_hold = 0;
   bit               idle_on = 1'b1;

   byte_ring_fifo #(.CAPACITY(CAPACITY)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles, %0d results outstanding", $realtime,
                  cycle_count, outcomes_due.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int ring_step(int idx, int step);
      int s;
      s = idx + step;
      if (s >= SLOTS) s -= SLOTS;
      return s;
   endfunction

   function automatic int ring_used();
      if (ring_rear >= ring_front) return ring_rear - ring_front;
      return ring_rear + SLOTS - ring_front;
   endfunction

   // Apply one action to the mirror and return the response it must produce
   function automatic fifo_outcome_type fifo_apply(logic [brf_pkg::ACTION_W-1:0] act,
                                                   logic [brf_pkg::BYTE_W-1:0] din,
                                                   logic [brf_pkg::COUNT_W-1:0] cnt);
      fifo_outcome_type res;
      int               used;
      res  = '0;
      used = ring_used();
      case (act)
         brf_pkg::ACT_PUSH: begin
            if (used >= CAPACITY) begin
               res.refused = 1'b1;
            end else begin
               ring_rear = ring_step(ring_rear, 1);
               ring_bytes[ring_rear] = din;
            end
         end
         brf_pkg::ACT_POP: begin
            if (used == 0) begin
               res.refused = 1'b1;
            end else begin
               ring_front = ring_step(ring_front, 1);
               res.read_byte = ring_bytes[ring_front];
            end
         end
         brf_pkg::ACT_PEEK: begin
            if (int'(cnt) >= used) res.refused = 1'b1;
            else res.read_byte = ring_bytes[ring_step(ring_front, int'(cnt) + 1)];
         end
         brf_pkg::ACT_SKIP: begin
            if (int'(cnt) > used) res.refused = 1'b1;
            else ring_front = ring_step(ring_front, int'(cnt));
         end
         brf_pkg::ACT_CLEAR: ring_front = ring_rear;
         default: ;
      endcase
      used = ring_used();
      res.used_bytes = brf_pkg::COUNT_W'(used);
      res.free_bytes = brf_pkg::COUNT_W'(CAPACITY - used);
      return res;
   endfunction

   // Offer one request, after a random gap while gaps are on, and hold it until the transfer
   task automatic send_item(logic [brf_pkg::ACTION_W-1:0] act, logic [brf_pkg::BYTE_W-1:0] din,
                            logic [brf_pkg::COUNT_W-1:0] cnt);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0, cnt, din};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      outcomes_due.push_back(fifo_apply(act, din, cnt));
   endtask

   task automatic report_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t %s mismatch: expected 0x%0h actual 0x%0h", $realtime, name, want, got);
         mismatch_count++;
      end
   endtask

   // Check each response transfer and draw the next stall
   always @(posedge clock) begin
      fifo_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcomes_due.size() == 0) begin
            $display("%0t unexpected response: expected none actual 0x%0h/0x%0h", $realtime,
                     rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = outcomes_due.pop_front();
            report_field("status", want.refused, rsp_tuser[0]);
            report_field("read_byte", want.read_byte, rsp_tdata[7:0]);
            report_field("used_bytes", want.used_bytes, rsp_tdata[19:8]);
            report_field("free_bytes", want.free_bytes, rsp_tdata[31:20]);
         end
         rsp_hold = idle_on ? $urandom_range(0, 4) : 0;
      end
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Empty FIFO right after reset: refusals, zero skip and the spare codes
   task automatic test_empty_fifo();
      send_item(brf_pkg::ACT_QUERY, 8'h00, 12'h000);
      send_item(brf_pkg::ACT_POP, 8'hFF, 12'hFFF);
      send_item(brf_pkg::ACT_PEEK, 8'h00, 12'h000);
      send_item(brf_pkg::ACT_SKIP, 8'h00, 12'h000);
      send_item(brf_pkg::ACT_SKIP, 8'h00, 12'h001);
      send_item(brf_pkg::ACT_CLEAR, 8'h00, 12'h000);
      send_item(ACT_SPARE_6, 8'hFF, 12'hFFF);
      send_item(ACT_SPARE_7, 8'h5A, 12'hA5A);
   endtask

   // Every action on a few bytes, with byte and offset extremes
   task automatic test_each_action();
      send_item(brf_pkg::ACT_PUSH, 8'h00, 12'h000);
      send_item(brf_pkg::ACT_PUSH, 8'hFF, 12'hFFF);
      send_item(brf_pkg::ACT_PUSH, 8'hA5, 12'h000);
      send_item(brf_pkg::ACT_PUSH, 8'h5A, 12'h000);
      send_item(brf_pkg::ACT_PEEK, 8'h00, 12'h000);
      send_item(brf_pkg::ACT_PEEK, 8'h00, 12'h003);
      send_item(brf_pkg::ACT_PEEK, 8'h00, 12'h004);
      send_item(brf_pkg::ACT_PEEK, 8'h00, 12'hFFF);
      send_item(brf_pkg::ACT_POP, 8'h00, 12'h000);
      send_item(brf_pkg::ACT_SKIP, 8'h00, 12'h002);
      send_item(brf_pkg::ACT_SKIP, 8'h00, 12'hFFF);
      send_item(brf_pkg::ACT_POP, 8'h00, 12'h000);
      send_item(brf_pkg::ACT_PUSH, 8'h3C, 12'h000);
      send_item(brf_pkg::ACT_PUSH, 8'hC3, 12'h000);
      send_item(brf_pkg::ACT_CLEAR, 8'h00, 12'h000);
      send_item(brf_pkg::ACT_QUERY, 8'h00, 12'h000);
      send_item(brf_pkg::ACT_POP, 8'h00, 12'h000);
   endtask

   // Fill deep, peek at and past the far end, pop and refill, then drain by skips
   task automatic test_deep_fill();
      while (ring_used() < DEEP_FILL)
         send_item(brf_pkg::ACT_PUSH, 8'($urandom), 12'($urandom));
      send_item(brf_pkg::ACT_PEEK, 8'h00, 12'(DEEP_FILL - 1));
      send_item(brf_pkg::ACT_PEEK, 8'h00, 12'(DEEP_FILL));
      send_item(brf_pkg::ACT_PEEK, 8'h00, 12'hFFF);
      repeat (150) send_item(brf_pkg::ACT_POP, 8'($urandom), 12'($urandom));
      repeat (150) send_item(brf_pkg::ACT_PUSH, 8'($urandom), 12'($urandom));
      send_item(brf_pkg::ACT_PEEK, 8'h00, 12'(ring_used() - 1));
      send_item(brf_pkg::ACT_SKIP, 8'h00, 12'(ring_used() + 1));
      send_item(brf_pkg::ACT_SKIP, 8'h00, 12'(ring_used()));
      send_item(brf_pkg::ACT_QUERY, 8'h00, 12'h000);
      repeat (40) send_item(brf_pkg::ACT_PUSH, 8'($urandom), 12'($urandom));
      send_item(brf_pkg::ACT_SKIP, 8'h00, 12'h028);
   endtask

   // Mixed traffic, mostly legal offsets, with idle-free stretches
   task automatic test_random_traffic();
      int                           pick;
      int                           used;
      logic [brf_pkg::ACTION_W-1:0] act;
      logic [brf_pkg::COUNT_W-1:0]  cnt;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = ((n / 150) % 3) != 2;
         pick = $urandom_range(0, 99);
         used = ring_used();
         cnt  = 12'($urandom);
         if (pick < 40) begin
            act = brf_pkg::ACT_PUSH;
         end else if (pick < 65) begin
            act = brf_pkg::ACT_POP;
         end else if (pick < 80) begin
            act = brf_pkg::ACT_PEEK;
            if (used > 0 && $urandom_range(0, 4) != 0) cnt = 12'($urandom_range(0, used - 1));
         end else if (pick < 88) begin
            act = brf_pkg::ACT_SKIP;
            if ($urandom_range(0, 3) != 0)
               cnt = 12'($urandom_range(0, (used < 8) ? used : 8));
         end else if (pick < 91) begin
            act = brf_pkg::ACT_CLEAR;
         end else if (pick < 96) begin
            act = brf_pkg::ACT_QUERY;
         end else begin
            act = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
         end
         send_item(act, 8'($urandom), cnt);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_fifo();
      test_each_action();
      test_deep_fill();
      test_random_traffic();
      req_tvalid <= 1'b0;
      // Let every outstanding response drain, then watch for strays
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
